// ===== rtl/zsbf_pkg.sv =====
// ----------------------------------------------------------------------------
// zsbf_pkg: shared types and constants of the zlib stored block framer
// Slot codes of the output byte sequence, the item descriptor and constants.
// ----------------------------------------------------------------------------
package zsbf_pkg;

    localparam logic [15:0] MAX_BLOCK_BYTES_DEFAULT = 16'hFFFF;
    localparam logic [15:0] ADLER_MOD               = 16'd65521;
    localparam logic [7:0]  ZLIB_CMF                = 8'h78;
    localparam logic [7:0]  ZLIB_FLG                = 8'h01;

    localparam logic [0:0]  ACTION_START = 1'b0;
    localparam logic [0:0]  ACTION_BYTE  = 1'b1;

    localparam int unsigned SLOT_W = 4;

    localparam logic [SLOT_W-1:0] SLOT_CMF     = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_FLG     = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_BFINAL  = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_LEN_LO  = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_LEN_HI  = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_NLEN_LO = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_NLEN_HI = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_DATA    = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_ADH_HI  = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_ADH_LO  = 4'd9;
    localparam logic [SLOT_W-1:0] SLOT_ADL_HI  = 4'd10;
    localparam logic [SLOT_W-1:0] SLOT_ADL_LO  = 4'd11;

    localparam logic [0:0] CFG_TOTAL_LENGTH = 1'b0;

    typedef struct packed {
        logic        has_zhdr;
        logic        has_bhdr;
        logic        has_data;
        logic        has_trl;
        logic        err;
        logic        bfinal;
        logic [15:0] blen;
        logic [7:0]  data;
        logic [15:0] adler_high;
        logic [15:0] adler_low;
    } desc_t;

endpackage

// ===== rtl/zsbf_engine.sv =====
// ----------------------------------------------------------------------------
// zsbf_engine: stream state and per-item decision
// Holds the Adler sums and byte counters and builds the item descriptor.
// ----------------------------------------------------------------------------
module zsbf_engine #(
    parameter logic [15:0] MAX_BLOCK_BYTES = zsbf_pkg::MAX_BLOCK_BYTES_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 action,
    input  logic [7:0]           payload_byte,
    input  logic [31:0]          total_length,
    output zsbf_pkg::desc_t      desc
);

    logic [15:0] low_reg, low_next;
    logic [15:0] high_reg, high_next;
    logic [31:0] left_total_reg, left_total_next;
    logic [15:0] left_block_reg, left_block_next;
    logic        active_reg, active_next;

    logic [16:0] low_sum;
    logic [15:0] low_upd;
    logic [16:0] high_sum;
    logic [15:0] high_upd;
    logic [15:0] chunk;
    logic        chunk_final;
    logic [31:0] total_dec;

    always_comb
    begin
        low_sum  = {1'b0, low_reg} + {9'b0, payload_byte};
        low_upd  = (low_sum >= {1'b0, zsbf_pkg::ADLER_MOD})
                 ? 16'(low_sum - {1'b0, zsbf_pkg::ADLER_MOD}) : low_sum[15:0];
        high_sum = {1'b0, high_reg} + {1'b0, low_upd};
        high_upd = (high_sum >= {1'b0, zsbf_pkg::ADLER_MOD})
                 ? 16'(high_sum - {1'b0, zsbf_pkg::ADLER_MOD}) : high_sum[15:0];

        chunk_final = (left_total_reg <= {16'b0, MAX_BLOCK_BYTES});
        chunk       = chunk_final ? left_total_reg[15:0] : MAX_BLOCK_BYTES;
        total_dec   = left_total_reg - 32'd1;

        low_next        = low_reg;
        high_next       = high_reg;
        left_total_next = left_total_reg;
        left_block_next = left_block_reg;
        active_next     = active_reg;

        desc            = '0;
        desc.data       = payload_byte;
        desc.adler_high = high_upd;
        desc.adler_low  = low_upd;

        if (action == zsbf_pkg::ACTION_START)
        begin
            low_next        = 16'd1;
            high_next       = 16'd0;
            left_total_next = total_length;
            left_block_next = 16'd0;
            active_next     = (total_length != 32'd0);
            desc.has_zhdr   = 1'b1;
            if (total_length == 32'd0)
            begin
                desc.has_bhdr   = 1'b1;
                desc.bfinal     = 1'b1;
                desc.blen       = 16'd0;
                desc.has_trl    = 1'b1;
                desc.adler_high = 16'd0;
                desc.adler_low  = 16'd1;
            end
        end
        else if (!active_reg || left_total_reg == 32'd0)
        begin
            desc.has_data = 1'b1;
            desc.err      = 1'b1;
        end
        else
        begin
            desc.has_data   = 1'b1;
            low_next        = low_upd;
            high_next       = high_upd;
            left_total_next = total_dec;
            if (left_block_reg == 16'd0)
            begin
                desc.has_bhdr   = 1'b1;
                desc.bfinal     = chunk_final;
                desc.blen       = chunk;
                left_block_next = chunk - 16'd1;
            end
            else
            begin
                left_block_next = left_block_reg - 16'd1;
            end
            if (total_dec == 32'd0)
            begin
                desc.has_trl    = 1'b1;
                active_next     = 1'b0;
                left_block_next = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg        <= 16'd1;
            high_reg       <= 16'd0;
            left_total_reg <= 32'd0;
            left_block_reg <= 16'd0;
            active_reg     <= 1'b0;
        end
        else if (accept)
        begin
            low_reg        <= low_next;
            high_reg       <= high_next;
            left_total_reg <= left_total_next;
            left_block_reg <= left_block_next;
            active_reg     <= active_next;
        end
    end

endmodule

// ===== rtl/zsbf_emitter.sv =====
// ----------------------------------------------------------------------------
// zsbf_emitter: descriptor register and byte serializer
// Walks the slots present in a descriptor, one byte into the output register.
// ----------------------------------------------------------------------------
module zsbf_emitter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  zsbf_pkg::desc_t      desc_in,
    output logic                 ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast,
    output logic [1:0]           m_tuser
);

    zsbf_pkg::desc_t desc_reg;
    logic            desc_valid_reg, desc_valid_next;
    logic [zsbf_pkg::SLOT_W-1:0] slot_reg, slot_next, slot_after, slot_first;
    logic            slot_end;
    logic            emit;
    logic            last;
    logic [7:0]      byte_sel;
    logic            out_valid_reg;
    logic [7:0]      out_data_reg;
    logic            out_last_reg;
    logic [1:0]      out_user_reg;

    always_comb
    begin
        slot_first = desc_in.has_zhdr ? zsbf_pkg::SLOT_CMF
                   : (desc_in.has_bhdr ? zsbf_pkg::SLOT_BFINAL : zsbf_pkg::SLOT_DATA);

        slot_after = slot_reg + 4'd1;
        slot_end   = 1'b0;
        case (slot_reg)
            zsbf_pkg::SLOT_FLG,
            zsbf_pkg::SLOT_NLEN_HI:
            begin
                if (slot_reg == zsbf_pkg::SLOT_FLG && desc_reg.has_bhdr)
                    slot_after = zsbf_pkg::SLOT_BFINAL;
                else if (desc_reg.has_data)
                    slot_after = zsbf_pkg::SLOT_DATA;
                else if (desc_reg.has_trl)
                    slot_after = zsbf_pkg::SLOT_ADH_HI;
                else
                    slot_end = 1'b1;
            end
            zsbf_pkg::SLOT_DATA:
            begin
                slot_after = zsbf_pkg::SLOT_ADH_HI;
                slot_end   = !desc_reg.has_trl;
            end
            zsbf_pkg::SLOT_ADL_LO:
                slot_end = 1'b1;
            default:
                slot_after = slot_reg + 4'd1;
        endcase

        case (slot_reg)
            zsbf_pkg::SLOT_CMF:     byte_sel = zsbf_pkg::ZLIB_CMF;
            zsbf_pkg::SLOT_FLG:     byte_sel = zsbf_pkg::ZLIB_FLG;
            zsbf_pkg::SLOT_BFINAL:  byte_sel = {7'b0, desc_reg.bfinal};
            zsbf_pkg::SLOT_LEN_LO:  byte_sel = desc_reg.blen[7:0];
            zsbf_pkg::SLOT_LEN_HI:  byte_sel = desc_reg.blen[15:8];
            zsbf_pkg::SLOT_NLEN_LO: byte_sel = ~desc_reg.blen[7:0];
            zsbf_pkg::SLOT_NLEN_HI: byte_sel = ~desc_reg.blen[15:8];
            zsbf_pkg::SLOT_DATA:    byte_sel = desc_reg.err ? 8'h00 : desc_reg.data;
            zsbf_pkg::SLOT_ADH_HI:  byte_sel = desc_reg.adler_high[15:8];
            zsbf_pkg::SLOT_ADH_LO:  byte_sel = desc_reg.adler_high[7:0];
            zsbf_pkg::SLOT_ADL_HI:  byte_sel = desc_reg.adler_low[15:8];
            zsbf_pkg::SLOT_ADL_LO:  byte_sel = desc_reg.adler_low[7:0];
            default:                byte_sel = 8'h00;
        endcase

        emit  = desc_valid_reg && (!out_valid_reg || m_tready);
        last  = emit && slot_end;
        ready = !desc_valid_reg || last;

        desc_valid_next = load ? 1'b1 : (last ? 1'b0 : desc_valid_reg);
        slot_next       = load ? slot_first : (emit ? slot_after : slot_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
            slot_reg       <= zsbf_pkg::SLOT_CMF;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            desc_valid_reg <= desc_valid_next;
            slot_reg       <= slot_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            desc_reg <= desc_in;
        if (emit)
        begin
            out_data_reg <= byte_sel;
            out_last_reg <= slot_end;
            out_user_reg <= {desc_reg.err && slot_reg == zsbf_pkg::SLOT_DATA,
                             slot_reg == zsbf_pkg::SLOT_ADL_LO};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== rtl/zlib_stored_block_framer.sv =====
// ----------------------------------------------------------------------------
// zlib_stored_block_framer: zlib stream of stored deflate blocks
// A start item gives the zlib header, payload bytes pass through with stored
// block headers in front of each block and the Adler-32 trailer after the last.
// ----------------------------------------------------------------------------
// Unless the output stalls, an item is taken every cycle as long as each item
// yields one output byte; an item that yields n bytes (start: 2 or 11, first
// byte of a block: 6, last byte: 5 or 10) holds the input until all are sent,
// since the serializer sends one byte per cycle from its descriptor register
// into the output register. total_length is sampled at the start item; a
// byte before start or past the length gives one item with protocol_error set.
module zlib_stored_block_framer #(
    parameter logic [15:0] MAX_BLOCK_BYTES = zsbf_pkg::MAX_BLOCK_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] payload_byte
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] stream_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [0] stream_done, [1] protocol_error
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic            accept;
    logic            emit_ready;
    logic [31:0]     total_length_reg;
    zsbf_pkg::desc_t desc;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == zsbf_pkg::CFG_TOTAL_LENGTH) ? total_length_reg : 32'd0;
    assign s_tready = emit_ready;
    assign accept   = s_tvalid && emit_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_length_reg <= 32'd0;
        else if (psel && penable && pwrite && pready
                 && paddr[2] == zsbf_pkg::CFG_TOTAL_LENGTH)
            total_length_reg <= pwdata;
    end

    zsbf_engine #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .action       (s_tuser),
        .payload_byte (s_tdata),
        .total_length (total_length_reg),
        .desc         (desc)
    );

    zsbf_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .desc_in  (desc),
        .ready    (emit_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/zsbf_checker.sv =====
// ----------------------------------------------------------------------------
// zsbf_checker: port-level checks of the zlib stored block framer
// Output flag consistency and output hold under backpressure.
// ----------------------------------------------------------------------------
module zsbf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("stream_done without last_of_run");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast && m_tdata == 8'h00 && !m_tuser[0])
        else $error("malformed protocol error item");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tlast))
        else $error("last_of_run changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

endmodule

bind zlib_stored_block_framer zsbf_checker u_zsbf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/zlib_stored_block_framer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zlib_stored_block_framer_tb: self-checking bench of the stored block framer
// Drives start and payload items on the input stream and total_length over
// APB, predicts every zlib output byte (zlib header, stored block headers,
// payload, Adler-32 trailer, error items) and compares each output item in
// order. Runs directed cases, a long output stall and random streams under
// several idle and stall mixes.
// ----------------------------------------------------------------------------
module zlib_stored_block_framer_tb;

    localparam int          HALF_PERIOD    = 6;
    localparam int          RESET_CYCLES   = 9;
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          HOLD_OFF_LEN   = 300;
    localparam int unsigned BLOCK_MAX      = zsbf_pkg::MAX_BLOCK_BYTES_DEFAULT;
    localparam logic [2:0]  ADDR_TOTAL_LEN = {zsbf_pkg::CFG_TOTAL_LENGTH, 2'b00};

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       done;
        logic       err;
    } zlib_byte_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] payload_byte
    logic        s_tuser;   // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // [7:0] stream_byte
    logic        m_tlast;
    logic [1:0]  m_tuser;   // [0] stream_done, [1] protocol_error
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    zlib_byte_t  zlib_bytes_q[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          hold_req = 0;
    int          hold_ack = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    // framer state as predicted
    logic [31:0] total_len_cfg = '0;
    logic [31:0] left_total = '0;
    logic [15:0] left_block = '0;
    int unsigned adler_a = 1;
    int unsigned adler_b = 0;
    logic        stream_on = 1'b0;

    zlib_stored_block_framer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic push_zbyte(input logic [7:0] data, input logic done, input logic err);
        zlib_byte_t zb;
        zb.data = data;
        zb.last = 1'b0;
        zb.done = done;
        zb.err  = err;
        zlib_bytes_q.insert(zlib_bytes_q.size(), zb);
    endtask

    task automatic push_block_header(input logic [15:0] len, input logic fin);
        logic [15:0] nlen;
        nlen = ~len;
        push_zbyte(fin ? 8'h01 : 8'h00, 1'b0, 1'b0);
        push_zbyte(len[7:0], 1'b0, 1'b0);
        push_zbyte(len[15:8], 1'b0, 1'b0);
        push_zbyte(nlen[7:0], 1'b0, 1'b0);
        push_zbyte(nlen[15:8], 1'b0, 1'b0);
    endtask

    task automatic push_adler_trailer();
        logic [15:0] hi;
        logic [15:0] lo;
        hi = 16'(adler_b);
        lo = 16'(adler_a);
        push_zbyte(hi[15:8], 1'b0, 1'b0);
        push_zbyte(hi[7:0], 1'b0, 1'b0);
        push_zbyte(lo[15:8], 1'b0, 1'b0);
        push_zbyte(lo[7:0], 1'b1, 1'b0);
    endtask

    task automatic frame_item(input logic act, input logic [7:0] b);
        int unsigned chunk;
        zlib_byte_t  tail;
        if (act == zsbf_pkg::ACTION_START)
        begin
            adler_a    = 1;
            adler_b    = 0;
            left_total = total_len_cfg;
            left_block = '0;
            push_zbyte(zsbf_pkg::ZLIB_CMF, 1'b0, 1'b0);
            push_zbyte(zsbf_pkg::ZLIB_FLG, 1'b0, 1'b0);
            if (left_total == 0)
            begin
                push_block_header(16'h0000, 1'b1);
                push_adler_trailer();
                stream_on = 1'b0;
            end
            else
                stream_on = 1'b1;
        end
        else if (!stream_on || left_total == 0)
            push_zbyte(8'h00, 1'b0, 1'b1);
        else
        begin
            if (left_block == 0)
            begin
                chunk = (left_total > BLOCK_MAX) ? BLOCK_MAX : left_total;
                push_block_header(16'(chunk), left_total <= BLOCK_MAX);
                left_block = 16'(chunk);
            end
            push_zbyte(b, 1'b0, 1'b0);
            left_block = left_block - 16'd1;
            left_total = left_total - 32'd1;
            adler_a = adler_a + b;
            if (adler_a >= zsbf_pkg::ADLER_MOD)
                adler_a = adler_a - zsbf_pkg::ADLER_MOD;
            adler_b = adler_b + adler_a;
            if (adler_b >= zsbf_pkg::ADLER_MOD)
                adler_b = adler_b - zsbf_pkg::ADLER_MOD;
            if (left_total == 0)
            begin
                push_adler_trailer();
                stream_on  = 1'b0;
                left_block = '0;
            end
        end
        tail = zlib_bytes_q[zlib_bytes_q.size() - 1];
        tail.last = 1'b1;
        zlib_bytes_q[zlib_bytes_q.size() - 1] = tail;
    endtask

    task automatic send_item(input logic act, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        frame_item(act, b);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // drop valid and wait for every predicted byte, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (zlib_bytes_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_total_length(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TOTAL_LEN;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        total_len_cfg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== value)
        begin
            $display("%0t total_length readback expected %h actual %h", $time, value, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_stream(input int len);
        send_item(zsbf_pkg::ACTION_START, 8'($urandom_range(255)));
        for (int i = 0; i < len; i++)
            send_item(zsbf_pkg::ACTION_BYTE, 8'($urandom_range(255)));
    endtask

    task automatic test_bytes_before_start();
        send_item(zsbf_pkg::ACTION_BYTE, 8'hA5);
        send_item(zsbf_pkg::ACTION_BYTE, 8'h5A);
        drain();
    endtask

    task automatic test_zero_length();
        write_total_length(32'd0);
        send_item(zsbf_pkg::ACTION_START, 8'h00);
        send_item(zsbf_pkg::ACTION_BYTE, 8'hFF);
        drain();
    endtask

    task automatic test_short_streams();
        write_total_length(32'd3);
        send_item(zsbf_pkg::ACTION_START, 8'hFF);
        send_item(zsbf_pkg::ACTION_BYTE, 8'h00);
        send_item(zsbf_pkg::ACTION_BYTE, 8'hFF);
        send_item(zsbf_pkg::ACTION_BYTE, 8'h80);
        send_item(zsbf_pkg::ACTION_BYTE, 8'h7F);
        drain();
        write_total_length(32'd1);
        send_item(zsbf_pkg::ACTION_START, 8'h00);
        send_item(zsbf_pkg::ACTION_BYTE, 8'h01);
        drain();
    endtask

    task automatic test_restart_while_active();
        write_total_length(32'd5);
        send_item(zsbf_pkg::ACTION_START, 8'h00);
        send_item(zsbf_pkg::ACTION_BYTE, 8'h11);
        send_item(zsbf_pkg::ACTION_BYTE, 8'h22);
        send_item(zsbf_pkg::ACTION_START, 8'h00);
        for (int i = 0; i < 5; i++)
            send_item(zsbf_pkg::ACTION_BYTE, 8'(8'h40 + i));
        drain();
    endtask

    task automatic test_max_length();
        write_total_length(32'hFFFF_FFFF);
        send_item(zsbf_pkg::ACTION_START, 8'h00);
        send_item(zsbf_pkg::ACTION_BYTE, 8'hC3);
        send_item(zsbf_pkg::ACTION_BYTE, 8'h3C);
        drain();
        write_total_length(32'd2);
        send_stream(2);
        drain();
    endtask

    task automatic test_output_hold_off();
        write_total_length(32'd40);
        hold_req <= hold_req + 1;
        send_stream(40);
        drain();
    endtask

    task automatic test_random_streams(input int src_pct, input int snk_pct, input int n_items);
        int stop_at;
        int pick;
        int len;
        int cut;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_item(zsbf_pkg::ACTION_BYTE, 8'($urandom_range(255)));
            else
            begin
                drain();
                len = $urandom_range(99);
                if (len < 5)
                    len = 0;
                else if (len < 90)
                    len = $urandom_range(12, 1);
                else
                    len = $urandom_range(60, 13);
                write_total_length(32'(len));
                cut = (pick >= 90) ? $urandom_range(len) : len;
                send_stream(cut);
                if (pick >= 80 && pick < 90)
                    for (int i = $urandom_range(2, 1); i > 0; i--)
                        send_item(zsbf_pkg::ACTION_BYTE, 8'($urandom_range(255)));
            end
        end
        drain();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
    endtask

    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_OFF_LEN;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        zlib_byte_t zb;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (zlib_bytes_q.size() == 0)
            begin
                $display("%0t unexpected item: expected none actual data %h last %b user %b",
                         $time, m_tdata, m_tlast, m_tuser);
                mismatches++;
            end
            else
            begin
                zb = zlib_bytes_q.pop_front();
                if (m_tdata !== zb.data)
                begin
                    $display("%0t stream_byte expected %h actual %h", $time, zb.data, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== zb.last)
                begin
                    $display("%0t last_of_run expected %b actual %b", $time, zb.last, m_tlast);
                    mismatches++;
                end
                if (m_tuser[0] !== zb.done)
                begin
                    $display("%0t stream_done expected %b actual %b", $time, zb.done, m_tuser[0]);
                    mismatches++;
                end
                if (m_tuser[1] !== zb.err)
                begin
                    $display("%0t protocol_error expected %b actual %b",
                             $time, zb.err, m_tuser[1]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no item moved for %0d cycles", $time, quiet_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= zsbf_pkg::ACTION_START;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_bytes_before_start();
        test_zero_length();
        test_short_streams();
        test_restart_while_active();
        test_max_length();
        test_output_hold_off();
        test_random_streams(0, 0, 35);
        test_random_streams(54, 0, 35);
        test_random_streams(0, 54, 35);
        test_random_streams(22, 22, 35);
        drain();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
